/* src/ptts_pkg.sv */
package ptts_pkg;

  // Table size and derived widths
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TOTAL_W    = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int PERIOD_W    = 24;
  localparam int TASK_IDX_W  = 3;
  localparam int TICK_MS_W   = 10;
  localparam int LIMIT_S_W   = 12;
  localparam int ELAPSED_W   = 32;
  localparam int PROD_W      = ELAPSED_W + TICK_MS_W;
  localparam int LIMIT_MS_W  = LIMIT_S_W + 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam int MS_PER_SECOND = 1000;

  // Reset values of the configuration registers
  localparam logic [TICK_MS_W-1:0] TICK_MS_RESET = TICK_MS_W'(10);
  localparam logic [LIMIT_S_W-1:0] LIMIT_S_RESET = LIMIT_S_W'(60);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT   = CFG_IDX_W'(1);

  // Command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_STOP   = 2'd3;

  // Event kinds
  localparam logic EVT_DUE  = 1'b0;
  localparam logic EVT_STOP = 1'b1;

  typedef struct packed {
    logic [1:0]          command;
    logic [PERIOD_W-1:0] period_ms;
    logic                task_present;
  } in_t;

  typedef struct packed {
    logic                  event_kind;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  last_of_run;
  } out_t;

  // One table entry
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] delay;
    logic                handler;
  } slot_t;

  // Low bits of a slot number as carried in task_index
  function automatic logic [TASK_IDX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+TASK_IDX_W-1:0] wide;
    wide = (SLOT_W + TASK_IDX_W)'(slot);
    return wide[TASK_IDX_W-1:0];
  endfunction

endpackage

/* src/ptts_task_ram.sv */
module ptts_task_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ptts_pkg::SLOT_W-1:0]   waddr,
  input  ptts_pkg::slot_t               wdata,
  input  logic                          re,
  input  logic [ptts_pkg::SLOT_W-1:0]   raddr,
  output ptts_pkg::slot_t               rdata
);

  ptts_pkg::slot_t mem [ptts_pkg::SLOT_COUNT];
  ptts_pkg::slot_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/periodic_task_tick_scheduler.sv */
// Periodic task tick scheduler. Slots are filled in order by create commands and held in a
// one-port-write, one-port-read task RAM; a start command sweeps the filled slots to reload
// every delay, and each tick while running walks the filled slots one per cycle (held while a
// due event waits on a stalled output), reading the next slot while the current one is written
// back, emitting a due event for each present task whose delay has run out, and then checks
// the run limit with a registered multiply. One transaction is worked at a time, and a
// transaction can be held while the result side stalls a pending event. The result
// register lets the next command be taken while the last result is still waiting.
// The RAM needs no clearing after reset: only slots below the fill count are ever read.
module periodic_task_tick_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ptts_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ptts_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [ptts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MUL,
    S_FIN,
    S_STOP
  } state_t;

  state_t state_r, state_nxt;

  logic [ptts_pkg::TICK_MS_W-1:0]  tick_r, tick_nxt;
  logic [ptts_pkg::LIMIT_S_W-1:0]  limit_r, limit_nxt;
  logic [ptts_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic                            running_r, running_nxt;
  logic [ptts_pkg::ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [ptts_pkg::SLOT_W-1:0]     idx_r, idx_nxt;
  logic                            walk_start_r, walk_start_nxt;
  logic                            pend_valid_r, pend_valid_nxt;
  logic [ptts_pkg::SLOT_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [ptts_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic [ptts_pkg::LIMIT_MS_W-1:0] lim_ms_r, lim_ms_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ptts_pkg::out_t                  out_data_r, out_data_nxt;

  logic                        mem_we;
  logic [ptts_pkg::SLOT_W-1:0] mem_waddr;
  ptts_pkg::slot_t             mem_wdata;
  logic                        mem_re;
  logic [ptts_pkg::SLOT_W-1:0] mem_raddr;
  ptts_pkg::slot_t             mem_rdata;

  logic                        can_push;
  logic                        push;
  ptts_pkg::out_t              push_data;
  logic                        last_slot;
  logic                        advance;
  logic                        timeout;
  logic [ptts_pkg::PERIOD_W-1:0] tick_ext;

  ptts_task_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign can_push  = !out_valid_r || !out_stall;
  assign last_slot = (ptts_pkg::TOTAL_W'(idx_r) == (total_r - ptts_pkg::TOTAL_W'(1)));
  assign timeout   = (prod_r >= ptts_pkg::PROD_W'(lim_ms_r));
  assign tick_ext  = ptts_pkg::PERIOD_W'(tick_r);

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    limit_nxt      = limit_r;
    total_nxt      = total_r;
    running_nxt    = running_r;
    elapsed_nxt    = elapsed_r;
    idx_nxt        = idx_r;
    walk_start_nxt = walk_start_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    prod_nxt       = prod_r;
    lim_ms_nxt     = lim_ms_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx_r;
    push           = 1'b0;
    push_data      = '0;
    advance        = 1'b0;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        ptts_pkg::REG_TICK_PERIOD: tick_nxt  = cfg_wdata[ptts_pkg::TICK_MS_W-1:0];
        ptts_pkg::REG_RUN_LIMIT:   limit_nxt = cfg_wdata[ptts_pkg::LIMIT_S_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.command)
            ptts_pkg::CMD_CREATE: begin
              // Fill the next free slot, drop when full
              if (total_r < ptts_pkg::TOTAL_W'(ptts_pkg::SLOT_COUNT)) begin
                mem_we            = 1'b1;
                mem_waddr         = total_r[ptts_pkg::SLOT_W-1:0];
                mem_wdata.period  = in_data.period_ms;
                mem_wdata.delay   = in_data.period_ms;
                mem_wdata.handler = in_data.task_present;
                total_nxt         = total_r + ptts_pkg::TOTAL_W'(1);
              end
            end
            ptts_pkg::CMD_START: begin
              elapsed_nxt = '0;
              running_nxt = 1'b1;
              if (total_r != '0) begin
                mem_re         = 1'b1;
                mem_raddr      = '0;
                idx_nxt        = '0;
                walk_start_nxt = 1'b1;
                state_nxt      = S_WALK;
              end
            end
            ptts_pkg::CMD_STOP: begin
              running_nxt = 1'b0;
              state_nxt   = S_STOP;
            end
            default: begin
              // Tick: count time, then walk the slots
              if (running_r) begin
                if (elapsed_r != '1) begin
                  elapsed_nxt = elapsed_r + ptts_pkg::ELAPSED_W'(1);
                end
                pend_valid_nxt = 1'b0;
                walk_start_nxt = 1'b0;
                if (total_r != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = '0;
                  idx_nxt   = '0;
                  state_nxt = S_WALK;
                end else begin
                  state_nxt = S_MUL;
                end
              end
            end
          endcase
        end
      end

      S_WALK: begin
        mem_waddr = idx_r;
        if (walk_start_r) begin
          // Reload the delay from the period
          mem_we          = 1'b1;
          mem_wdata.delay = mem_rdata.period;
          advance         = 1'b1;
        end else if (!mem_rdata.handler) begin
          advance = 1'b1;
        end else if (mem_rdata.delay <= tick_ext) begin
          // Due: flush the held event first, hold the walk if the output is busy
          if (!pend_valid_r || can_push) begin
            if (pend_valid_r) begin
              push                 = 1'b1;
              push_data.event_kind = ptts_pkg::EVT_DUE;
              push_data.task_index = ptts_pkg::slot_to_index(pend_idx_r);
              push_data.last_of_run = 1'b0;
            end
            pend_valid_nxt  = 1'b1;
            pend_idx_nxt    = idx_r;
            mem_we          = 1'b1;
            mem_wdata.delay = mem_rdata.period;
            advance         = 1'b1;
          end
        end else begin
          mem_we          = 1'b1;
          mem_wdata.delay = mem_rdata.delay - tick_ext;
          advance         = 1'b1;
        end

        // Step to the next slot, its read overlaps this write-back
        if (advance) begin
          if (last_slot) begin
            state_nxt = walk_start_r ? S_IDLE : S_MUL;
          end else begin
            idx_nxt   = idx_r + ptts_pkg::SLOT_W'(1);
            mem_re    = 1'b1;
            mem_raddr = idx_r + ptts_pkg::SLOT_W'(1);
          end
        end
      end

      S_MUL: begin
        // Elapsed milliseconds against the limit in milliseconds
        prod_nxt   = ptts_pkg::PROD_W'(elapsed_r) * ptts_pkg::PROD_W'(tick_r);
        lim_ms_nxt = ptts_pkg::LIMIT_MS_W'(limit_r) *
                     ptts_pkg::LIMIT_MS_W'(ptts_pkg::MS_PER_SECOND);
        state_nxt  = S_FIN;
      end

      S_FIN: begin
        if (!pend_valid_r || can_push) begin
          if (pend_valid_r) begin
            push                  = 1'b1;
            push_data.event_kind  = ptts_pkg::EVT_DUE;
            push_data.task_index  = ptts_pkg::slot_to_index(pend_idx_r);
            push_data.last_of_run = !timeout;
          end
          pend_valid_nxt = 1'b0;
          if (timeout) begin
            running_nxt = 1'b0;
            state_nxt   = S_STOP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_STOP: begin
        if (can_push) begin
          push                  = 1'b1;
          push_data.event_kind  = ptts_pkg::EVT_STOP;
          push_data.task_index  = '0;
          push_data.last_of_run = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Result register: load on push, drain when taken
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_r       <= ptts_pkg::TICK_MS_RESET;
      limit_r      <= ptts_pkg::LIMIT_S_RESET;
      total_r      <= '0;
      running_r    <= 1'b0;
      elapsed_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      limit_r      <= limit_nxt;
      total_r      <= total_nxt;
      running_r    <= running_nxt;
      elapsed_r    <= elapsed_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    walk_start_r <= walk_start_nxt;
    pend_idx_r   <= pend_idx_nxt;
    prod_r       <= prod_nxt;
    lim_ms_r     <= lim_ms_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

/* src/ptts_checker.sv */
module ptts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input ptts_pkg::in_t                   in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input ptts_pkg::out_t                  out_data
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Stop events carry slot zero and close their run
  a_stop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == ptts_pkg::EVT_STOP |->
      out_data.task_index == '0 && out_data.last_of_run)
    else $error("malformed stop event");

  // Create finishes in the cycle it is taken
  a_create_one: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall && in_data.command == ptts_pkg::CMD_CREATE |=> !in_stall)
    else $error("create held the input");

  // Stop must hold the input while its event is produced
  a_stop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall && in_data.command == ptts_pkg::CMD_STOP |=> in_stall)
    else $error("stop did not produce its event");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Spare register indexes: writes there must have no effect
  localparam logic [ptts_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = ptts_pkg::CFG_IDX_W'(2);
  localparam logic [ptts_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = ptts_pkg::CFG_IDX_W'(3);
  // Settling margin after the longest tick sweep and its stop event
  localparam int SETTLE_CYCLES = 40;
  localparam longint unsigned MS_PER_S = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ptts_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ptts_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [ptts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ptts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Commands waiting to be driven and events the scheduler owes us
  ptts_pkg::in_t pending_cmds[$];
  ptts_pkg::out_t expected_events[$];
  ptts_pkg::out_t next_event;
  int fail_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  bit no_idle = 1'b0;

  // Shadow copy of the task table and timing registers
  logic [ptts_pkg::PERIOD_W-1:0] shadow_period[ptts_pkg::SLOT_COUNT];
  logic [ptts_pkg::PERIOD_W-1:0] shadow_delay[ptts_pkg::SLOT_COUNT];
  logic shadow_handler[ptts_pkg::SLOT_COUNT];
  int slots_used = 0;
  bit sched_running = 1'b0;
  logic [ptts_pkg::ELAPSED_W-1:0] elapsed_ticks = '0;
  logic [ptts_pkg::TICK_MS_W-1:0] tick_ms = ptts_pkg::TICK_MS_RESET;
  logic [ptts_pkg::LIMIT_S_W-1:0] limit_s = ptts_pkg::LIMIT_S_RESET;

  periodic_task_tick_scheduler dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow scheduler by one command and queue the events it emits
  task automatic schedule_step(input ptts_pkg::in_t cmd);
    ptts_pkg::out_t evts[$];
    ptts_pkg::out_t evt;
    case (cmd.command)
      ptts_pkg::CMD_CREATE: begin
        if (slots_used < ptts_pkg::SLOT_COUNT) begin
          shadow_period[slots_used] = cmd.period_ms;
          shadow_delay[slots_used] = cmd.period_ms;
          shadow_handler[slots_used] = cmd.task_present;
          slots_used++;
        end
      end
      ptts_pkg::CMD_START: begin
        for (int i = 0; i < slots_used; i++) shadow_delay[i] = shadow_period[i];
        elapsed_ticks = '0;
        sched_running = 1'b1;
      end
      ptts_pkg::CMD_STOP: begin
        sched_running = 1'b0;
        evt = '{event_kind: ptts_pkg::EVT_STOP, task_index: '0, last_of_run: 1'b0};
        evts.push_back(evt);
      end
      ptts_pkg::CMD_TICK: begin
        if (sched_running) begin
          if (elapsed_ticks != '1) elapsed_ticks++;
          for (int i = 0; i < slots_used; i++) begin
            if (shadow_handler[i]) begin
              // Due once the remaining delay fits inside one tick
              if (shadow_delay[i] <= ptts_pkg::PERIOD_W'(tick_ms)) begin
                evt = '{event_kind: ptts_pkg::EVT_DUE,
                        task_index: i[ptts_pkg::TASK_IDX_W-1:0], last_of_run: 1'b0};
                evts.push_back(evt);
                shadow_delay[i] = shadow_period[i];
              end else begin
                shadow_delay[i] = shadow_delay[i] - ptts_pkg::PERIOD_W'(tick_ms);
              end
            end
          end
          if (longint'(elapsed_ticks) * longint'(tick_ms) / MS_PER_S >= longint'(limit_s)) begin
            sched_running = 1'b0;
            evt = '{event_kind: ptts_pkg::EVT_STOP, task_index: '0, last_of_run: 1'b0};
            evts.push_back(evt);
          end
        end
      end
      default: ;
    endcase
    if (evts.size() > 0) evts[evts.size()-1].last_of_run = 1'b1;
    foreach (evts[k]) expected_events.push_back(evts[k]);
  endtask

  // Drive commands; hold each one until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) schedule_step(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_data <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side in bursts, with calm stretches in between
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      calm_left = $urandom_range(1, 40);
      out_stall <= 1'b0;
    end
  end

  // Check each result transaction against the oldest expected event
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d index %0d last %0d",
               out_data.event_kind, out_data.task_index, out_data.last_of_run);
        fail_count++;
      end else begin
        next_event = expected_events.pop_front();
        if (out_data.event_kind !== next_event.event_kind) begin
          $error("event_kind: expected %0d, got %0d", next_event.event_kind, out_data.event_kind);
          fail_count++;
        end
        if (out_data.task_index !== next_event.task_index) begin
          $error("task_index: expected %0d, got %0d", next_event.task_index, out_data.task_index);
          fail_count++;
        end
        if (out_data.last_of_run !== next_event.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d",
                 next_event.last_of_run, out_data.last_of_run);
          fail_count++;
        end
      end
    end
  end

  function automatic void push_cmd(input logic [1:0] command,
                                   input logic [ptts_pkg::PERIOD_W-1:0] period,
                                   input logic present);
    ptts_pkg::in_t cmd;
    cmd.command = command;
    cmd.period_ms = period;
    cmd.task_present = present;
    pending_cmds.push_back(cmd);
  endfunction

  // Wait until every command is taken and every event has arrived, then let the block settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || gap_left != 0 || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ptts_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ptts_pkg::REG_TICK_PERIOD) tick_ms = val[ptts_pkg::TICK_MS_W-1:0];
    else if (idx == ptts_pkg::REG_RUN_LIMIT) limit_s = val[ptts_pkg::LIMIT_S_W-1:0];
  endtask

  // Mostly start-tick-stop runs with random content, some loose commands as noise
  task automatic queue_random_traffic(input int target);
    int n;
    int ticks;
    n = 0;
    while (n < target) begin
      if ($urandom_range(0, 9) < 7) begin
        push_cmd(ptts_pkg::CMD_START, ptts_pkg::PERIOD_W'($urandom), 1'($urandom));
        n++;
        ticks = $urandom_range(1, 10);
        repeat (ticks) begin
          push_cmd(ptts_pkg::CMD_TICK, ptts_pkg::PERIOD_W'($urandom), 1'($urandom));
          n++;
        end
        // Table is full by now, so this create is dropped
        if ($urandom_range(0, 4) == 0) begin
          push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 1) == 0) begin
          push_cmd(ptts_pkg::CMD_STOP, ptts_pkg::PERIOD_W'($urandom), 1'($urandom));
          n++;
        end
      end else begin
        push_cmd(2'($urandom_range(0, 3)), ptts_pkg::PERIOD_W'($urandom), 1'($urandom));
        n++;
      end
    end
  endtask

  task automatic run_phase(input logic [ptts_pkg::CFG_DATA_W-1:0] tick_val,
                           input logic [ptts_pkg::CFG_DATA_W-1:0] limit_val, input int target,
                           input bit quiet);
    wait_idle();
    write_reg(ptts_pkg::REG_TICK_PERIOD, tick_val);
    write_reg(ptts_pkg::REG_RUN_LIMIT, limit_val);
    no_idle = quiet;
    queue_random_traffic(target);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stopped behavior, table fill and overflow, boundary delays, restarts
    push_cmd(ptts_pkg::CMD_TICK, '0, 1'b0);
    push_cmd(ptts_pkg::CMD_STOP, '0, 1'b0);
    push_cmd(ptts_pkg::CMD_CREATE, '0, 1'b1);
    push_cmd(ptts_pkg::CMD_CREATE, '1, 1'b1);
    push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'(25), 1'b1);
    push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'(30), 1'b0);
    push_cmd(ptts_pkg::CMD_START, '0, 1'b0);
    repeat (3) push_cmd(ptts_pkg::CMD_TICK, '1, 1'b1);
    push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'(10), 1'b1);
    push_cmd(ptts_pkg::CMD_TICK, '0, 1'b0);
    push_cmd(ptts_pkg::CMD_START, '1, 1'b1);
    push_cmd(ptts_pkg::CMD_TICK, '0, 1'b0);
    push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'($urandom_range(0, 5000)), 1'b1);
    push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'($urandom_range(0, 5000)), 1'b1);
    push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'($urandom_range(0, 5000)), 1'b1);
    push_cmd(ptts_pkg::CMD_CREATE, ptts_pkg::PERIOD_W'(24'hAAAAAA), 1'b1);
    repeat (2) push_cmd(ptts_pkg::CMD_TICK, '0, 1'b0);
    push_cmd(ptts_pkg::CMD_STOP, '0, 1'b0);
    push_cmd(ptts_pkg::CMD_STOP, '0, 1'b0);

    // Random phases across timing settings, extremes included
    run_phase(ptts_pkg::CFG_DATA_W'(1000), ptts_pkg::CFG_DATA_W'(3), 25, 1'b0);
    run_phase('0, '0, 20, 1'b0);
    wait_idle();
    write_reg(REG_SPARE_LO, ptts_pkg::CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, ptts_pkg::CFG_DATA_W'($urandom));
    run_phase('1, '1, 25, 1'b0);
    run_phase('0, ptts_pkg::CFG_DATA_W'(5), 15, 1'b0);
    run_phase(ptts_pkg::CFG_DATA_W'(250), ptts_pkg::CFG_DATA_W'(2), 25, 1'b0);
    run_phase(ptts_pkg::CFG_DATA_W'($urandom_range(1, 1000)),
              ptts_pkg::CFG_DATA_W'($urandom_range(1, 3)), 30, 1'b1);

    wait_idle();
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
